/* sv/edd_pkg.sv */
`timescale 1ns / 1ps

package edd_pkg;

    // request codes
    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_PROC   = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;

    localparam int CHAR_W = 8;
    localparam int DIST_W = 6;
    localparam logic [DIST_W-1:0] DIST_MAX = 6'd63;

    // control from the sequencer to the row unit
    typedef struct packed {
        logic start;      // begin a row: write entry 0, seed diag and left
        logic issue;      // a read of the next row entry goes out this cycle
        logic first_row;  // no row written yet, entry j reads as j
    } row_ctl_t;

endpackage

/* sv/edd_pattern_mem.sv */
`timescale 1ns / 1ps

module edd_pattern_mem
    import edd_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [CHAR_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [CHAR_W-1:0] rdata
);

    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] rdata_reg;

    // single write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/edd_row_unit.sv */
`timescale 1ns / 1ps

module edd_row_unit
    import edd_pkg::*;
#(
    parameter int DEPTH = 33,
    parameter int CW    = 6
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  row_ctl_t          ctl,
    input  logic [CW-1:0]     row_num,
    input  logic [CW-1:0]     rd_addr,
    input  logic [CHAR_W-1:0] ch,
    input  logic [CHAR_W-1:0] pat_q,
    output logic [CW-1:0]     rd_data
);

    logic [CW-1:0] mem [DEPTH];
    logic [CW-1:0] q_reg;
    logic [CW-1:0] diag_reg;
    logic [CW-1:0] diag_next;
    logic [CW-1:0] left_reg;
    logic [CW-1:0] left_next;
    logic          cmp_vld_reg;
    logic [CW-1:0] cmp_idx_reg;
    logic [CW-1:0] up;
    logic [CW:0]   up_p1;
    logic [CW:0]   left_p1;
    logic [CW:0]   sub_cost;
    logic [CW:0]   min_ab;
    logic [CW:0]   min_all;
    logic [CW-1:0] row_num_p1;
    logic          we;
    logic [CW-1:0] waddr;
    logic [CW-1:0] wdata;

    assign row_num_p1 = row_num + CW'(1);

    // recurrence for the entry whose read came back this cycle
    always_comb
    begin
        up       = ctl.first_row ? cmp_idx_reg : q_reg;
        up_p1    = {1'b0, up} + (CW+1)'(1);
        left_p1  = {1'b0, left_reg} + (CW+1)'(1);
        sub_cost = {1'b0, diag_reg} + (CW+1)'(pat_q != ch);
        min_ab   = (up_p1 < left_p1) ? up_p1 : left_p1;
        min_all  = (min_ab < sub_cost) ? min_ab : sub_cost;
    end

    // write port: entry 0 on start, computed entry otherwise
    always_comb
    begin
        we        = ctl.start || cmp_vld_reg;
        waddr     = ctl.start ? '0 : cmp_idx_reg;
        wdata     = ctl.start ? row_num_p1 : min_all[CW-1:0];
        diag_next = diag_reg;
        left_next = left_reg;
        if (ctl.start)
        begin
            diag_next = row_num;
            left_next = row_num_p1;
        end
        else if (cmp_vld_reg)
        begin
            diag_next = up;
            left_next = min_all[CW-1:0];
        end
    end

    // cost row memory
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        q_reg <= mem[rd_addr];
    end

    // read-to-compute alignment
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            cmp_vld_reg <= ctl.issue;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= rd_addr;
        diag_reg    <= diag_next;
        left_reg    <= left_next;
    end

    assign rd_data = q_reg;

endmodule

/* sv/edit_distance_engine.sv */
`timescale 1ns / 1ps

// Levenshtein edit distance engine. Load requests store first-string bytes
// in a pattern memory; process requests stream second-string bytes, each
// one sweeping the cost row memory one entry per cycle, so a process request
// holds off further requests through the sweep over the P loaded pattern
// characters and a drain step (none when P is zero), bounded by the single
// read and write port of the row memory. A finish request holds off further
// requests until the result register is free, then emits the distance and
// overflow flag and returns the engine to its reset state. Bytes beyond
// MAX_LEN in either string are dropped and set the overflow flag; loads after
// the first processed byte are ignored. No clearing pass is needed after reset.
module edit_distance_engine
    import edd_pkg::*;
#(
    parameter int MAX_LEN = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  logic [1:0]        req_type,
    input  logic [CHAR_W-1:0] char_value,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [DIST_W-1:0] distance,
    output logic              overflow
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int PW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROW   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [CW-1:0]     pc_reg;
    logic [CW-1:0]     pc_next;
    logic [CW-1:0]     tc_reg;
    logic [CW-1:0]     tc_next;
    logic              ovf_reg;
    logic              ovf_next;
    logic [CW-1:0]     rd_idx_reg;
    logic [CW-1:0]     rd_idx_next;
    logic [CHAR_W-1:0] ch_reg;
    logic [CHAR_W-1:0] ch_next;
    logic              res_vld_reg;
    logic              res_vld_next;
    logic [DIST_W-1:0] dist_reg;
    logic [DIST_W-1:0] dist_next;
    logic              res_ovf_reg;
    logic              res_ovf_next;

    logic              req_acc;
    logic              res_free;
    logic              pc_full;
    logic              tc_full;
    logic              pat_we;
    logic [CW-1:0]     rd_idx_m1;
    logic [CW-1:0]     row_rd_addr;
    logic [CW-1:0]     row_q;
    logic [CHAR_W-1:0] pat_q;
    logic [CW-1:0]     fin_cost;
    logic [CW+5:0]     fin_ext;
    row_ctl_t          row_ctl;

    assign req_stall = (state_reg != ST_IDLE);
    assign req_acc   = req_valid && !req_stall;
    assign res_free  = !res_vld_reg || !result_stall;
    assign pc_full   = (pc_reg == CW'(MAX_LEN));
    assign tc_full   = (tc_reg == CW'(MAX_LEN));
    assign rd_idx_m1 = rd_idx_reg - CW'(1);

    // pattern write on an accepted load that fits, before any byte is processed
    assign pat_we = req_acc && (req_type == REQ_LOAD) && (tc_reg == '0) && !pc_full;

    // row reads sweep during a row update, otherwise sit on the final entry
    assign row_rd_addr = (state_reg == ST_ROW) ? rd_idx_reg : pc_reg;

    always_comb
    begin
        row_ctl.start     = req_acc && (req_type == REQ_PROC) && !tc_full;
        row_ctl.issue     = (state_reg == ST_ROW);
        row_ctl.first_row = (tc_reg == '0);
    end

    // distance from the final row entry, saturated to the field
    always_comb
    begin
        fin_cost = (tc_reg == '0) ? pc_reg : row_q;
        fin_ext  = (CW+6)'(fin_cost);
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        pc_next      = pc_reg;
        tc_next      = tc_reg;
        ovf_next     = ovf_reg;
        rd_idx_next  = rd_idx_reg;
        ch_next      = ch_reg;
        res_vld_next = res_vld_reg && result_stall;
        dist_next    = dist_reg;
        res_ovf_next = res_ovf_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_acc)
                begin
                    case (req_type)
                        REQ_LOAD:
                        begin
                            if (tc_reg == '0)
                            begin
                                if (pc_full)
                                begin
                                    ovf_next = 1'b1;
                                end
                                else
                                begin
                                    pc_next = pc_reg + CW'(1);
                                end
                            end
                        end
                        REQ_PROC:
                        begin
                            if (tc_full)
                            begin
                                ovf_next = 1'b1;
                            end
                            else if (pc_reg == '0)
                            begin
                                tc_next = tc_reg + CW'(1);
                            end
                            else
                            begin
                                ch_next     = char_value;
                                rd_idx_next = CW'(1);
                                state_next  = ST_ROW;
                            end
                        end
                        REQ_FINISH:
                        begin
                            state_next = ST_FIN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_ROW:
            begin
                rd_idx_next = rd_idx_reg + CW'(1);
                if (rd_idx_reg == pc_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                tc_next    = tc_reg + CW'(1);
                state_next = ST_IDLE;
            end
            ST_FIN:
            begin
                if (res_free)
                begin
                    res_vld_next = 1'b1;
                    res_ovf_next = ovf_reg;
                    if (fin_ext > (CW+6)'(DIST_MAX))
                    begin
                        dist_next = DIST_MAX;
                    end
                    else
                    begin
                        dist_next = fin_ext[DIST_W-1:0];
                    end
                    pc_next    = '0;
                    tc_next    = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pc_reg      <= '0;
            tc_reg      <= '0;
            ovf_reg     <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            tc_reg      <= tc_next;
            ovf_reg     <= ovf_next;
            res_vld_reg <= res_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg  <= rd_idx_next;
        ch_reg      <= ch_next;
        dist_reg    <= dist_next;
        res_ovf_reg <= res_ovf_next;
    end

    edd_pattern_mem #(
        .DEPTH (MAX_LEN),
        .AW    (PW)
    ) u_pattern_mem (
        .clk   (clk),
        .we    (pat_we),
        .waddr (pc_reg[PW-1:0]),
        .wdata (char_value),
        .raddr (rd_idx_m1[PW-1:0]),
        .rdata (pat_q)
    );

    edd_row_unit #(
        .DEPTH (MAX_LEN + 1),
        .CW    (CW)
    ) u_row_unit (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (row_ctl),
        .row_num (tc_reg),
        .rd_addr (row_rd_addr),
        .ch      (ch_reg),
        .pat_q   (pat_q),
        .rd_data (row_q)
    );

    assign result_valid = res_vld_reg;
    assign distance     = dist_reg;
    assign overflow     = res_ovf_reg;

`ifndef ASSERT_OFF
    // a row sweep only runs over a loaded pattern
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROW) |-> (pc_reg != '0))
        else $error("row sweep with empty pattern");

    // counts never pass the string limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (tc_reg <= CW'(MAX_LEN)) && (pc_reg <= CW'(MAX_LEN)))
        else $error("string count beyond limit");

    // a new result only comes out of the finish step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_vld_reg) |-> ($past(state_reg) == ST_FIN))
        else $error("result outside finish");

    // the sweep ends after the last pattern entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> (rd_idx_reg == pc_reg + CW'(1)))
        else $error("row sweep length mismatch");
`endif

endmodule

/* tb/edit_distance_checker.sv */
`timescale 1ns / 1ps

module edit_distance_checker
    import edd_pkg::*;
#(
    parameter int MAX_LEN = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_stall,
    input  logic [1:0]        req_type,
    input  logic [CHAR_W-1:0] char_value,
    input  logic              result_valid,
    input  logic              result_stall,
    input  logic [DIST_W-1:0] distance,
    input  logic              overflow,
    output int                mismatches,
    output int                outstanding
);

    typedef struct packed {
        logic [DIST_W-1:0] dist_val;
        logic              ovf;
    } edit_result_t;

    // mirror of the engine state
    logic [CHAR_W-1:0] pattern_chars [MAX_LEN];
    int unsigned       cost_row [0:MAX_LEN];
    int unsigned       pattern_len;
    int unsigned       text_len;
    logic              overflow_seen;

    edit_result_t      pending_distances [$];
    int                error_total;

    function automatic void clear_strings();
        pattern_len   = 0;
        text_len      = 0;
        overflow_seen = 1'b0;
        for (int j = 0; j <= MAX_LEN; j++)
        begin
            cost_row[j] = j;
        end
    endfunction

    // advance the dynamic-programming row for one accepted request
    function automatic void absorb_request(input logic [1:0] kind,
                                           input logic [CHAR_W-1:0] ch);
        int unsigned  diag;
        int unsigned  up;
        int unsigned  sub;
        int unsigned  best;
        int unsigned  d;
        edit_result_t res;
        case (kind)
            REQ_LOAD:
            begin
                // loads after streaming began are ignored
                if (text_len == 0)
                begin
                    if (pattern_len >= MAX_LEN)
                        overflow_seen = 1'b1;
                    else
                    begin
                        pattern_chars[pattern_len] = ch;
                        pattern_len++;
                    end
                end
            end
            REQ_PROC:
            begin
                if (text_len >= MAX_LEN)
                    overflow_seen = 1'b1;
                else
                begin
                    diag        = cost_row[0];
                    cost_row[0] = text_len + 1;
                    for (int i = 1; i <= pattern_len; i++)
                    begin
                        up   = cost_row[i];
                        sub  = diag + ((pattern_chars[i-1] == ch) ? 0 : 1);
                        best = up + 1;
                        if (cost_row[i-1] + 1 < best)
                            best = cost_row[i-1] + 1;
                        if (sub < best)
                            best = sub;
                        cost_row[i] = best;
                        diag        = up;
                    end
                    text_len++;
                end
            end
            REQ_FINISH:
            begin
                d = cost_row[pattern_len];
                if (d > DIST_MAX)
                    d = DIST_MAX;
                res.dist_val = d[DIST_W-1:0];
                res.ovf      = overflow_seen;
                pending_distances.push_back(res);
                clear_strings();
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        error_total++;
    endtask

    task automatic compare_result();
        edit_result_t want;
        if (pending_distances.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result distance=%0d overflow=%0d",
                                      distance, overflow));
            return;
        end
        want = pending_distances.pop_front();
        if (distance !== want.dist_val)
            report_mismatch($sformatf("distance %0d, expected %0d", distance,
                                      want.dist_val));
        if (overflow !== want.ovf)
            report_mismatch($sformatf("overflow %0d, expected %0d", overflow, want.ovf));
    endtask

    // results are checked before the request of the same edge is absorbed
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_strings();
            pending_distances.delete();
        end
        else
        begin
            if (result_valid && !result_stall)
                compare_result();
            if (req_valid && !req_stall)
                absorb_request(req_type, char_value);
        end
        outstanding <= pending_distances.size();
        mismatches  <= error_total;
    end

endmodule

/* tb/edit_distance_engine_test.sv */
`timescale 1ns / 1ps

module edit_distance_engine_test;
    import edd_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int         MAX_LEN    = 32;
    localparam int         NUM_ITEMS  = 1100;
    localparam int         CALM_AFTER = 950;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              req_valid    = 1'b0;
    logic              req_stall;
    logic [1:0]        req_type     = REQ_LOAD;
    logic [CHAR_W-1:0] char_value   = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic [DIST_W-1:0] distance;
    logic              overflow;

    int                mismatches;
    int                outstanding;
    int                sent_count   = 0;
    bit                idle_on      = 1'b0;
    int                stall_left   = 0;

    always #5 clk = ~clk;

    edit_distance_engine #(
        .MAX_LEN (MAX_LEN)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req_type     (req_type),
        .char_value   (char_value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .distance     (distance),
        .overflow     (overflow)
    );

    edit_distance_checker #(
        .MAX_LEN (MAX_LEN)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req_type     (req_type),
        .char_value   (char_value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .distance     (distance),
        .overflow     (overflow),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    // result side back-pressure in random bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left   <= stall_left - 1;
            result_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            stall_left   <= $urandom_range(0, 8);
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    // one request, with an optional idle burst ahead of it
    task automatic send_request(input logic [1:0] kind, input logic [CHAR_W-1:0] value);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        req_valid  <= 1'b1;
        req_type   <= kind;
        char_value <= value;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sent_count++;
    endtask

    function automatic logic [CHAR_W-1:0] pick_char(input logic [CHAR_W-1:0] base,
                                                     input int span);
        logic [CHAR_W-1:0] offset;
        offset = CHAR_W'($urandom_range(0, span - 1));
        return base + offset;
    endfunction

    // one pattern/text pair with random content, now and then broken by noise
    task automatic send_string_pair();
        int                pat_len;
        int                txt_len;
        int                mode;
        int                span;
        int                noise_at;
        int                late_load_at;
        logic [CHAR_W-1:0] pat_base;
        logic [CHAR_W-1:0] txt_base;
        mode     = $urandom_range(0, 9);
        span     = (mode < 2) ? 256 : $urandom_range(1, 4);
        pat_base = CHAR_W'($urandom);
        // disjoint alphabets drive the distance toward its maximum
        txt_base = (mode == 9) ? pat_base + 8'h80 : pat_base;
        pat_len  = ($urandom_range(0, 7) == 0) ? $urandom_range(20, MAX_LEN + 2)
                                               : $urandom_range(0, 8);
        txt_len  = ($urandom_range(0, 7) == 0) ? $urandom_range(20, MAX_LEN + 2)
                                               : $urandom_range(0, 8);
        noise_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, pat_len + txt_len) : -1;
        late_load_at = (txt_len > 0 && $urandom_range(0, 7) == 0)
                       ? $urandom_range(1, txt_len) : -1;
        for (int k = 0; k < pat_len + txt_len; k++)
        begin
            if (k == noise_at)
                send_request(REQ_UNUSED, CHAR_W'($urandom));
            if (k < pat_len)
                send_request(REQ_LOAD, pick_char(pat_base, span));
            else
            begin
                if (k - pat_len == late_load_at)
                    send_request(REQ_LOAD, CHAR_W'($urandom));
                send_request(REQ_PROC, pick_char(txt_base, span));
            end
        end
        if (noise_at == pat_len + txt_len)
            send_request(REQ_UNUSED, CHAR_W'($urandom));
        if (late_load_at == txt_len)
            send_request(REQ_LOAD, CHAR_W'($urandom));
        send_request(REQ_FINISH, CHAR_W'($urandom));
    endtask

    // stimulus
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty strings
        send_request(REQ_FINISH, 8'h00);
        // unused code changes nothing
        send_request(REQ_UNUSED, 8'hFF);
        send_request(REQ_FINISH, 8'hFF);
        // swapped extremes
        send_request(REQ_LOAD, 8'h00);
        send_request(REQ_LOAD, 8'hFF);
        send_request(REQ_PROC, 8'hFF);
        send_request(REQ_PROC, 8'h00);
        send_request(REQ_FINISH, 8'h00);
        // load after streaming began is ignored
        send_request(REQ_LOAD, 8'h5A);
        send_request(REQ_PROC, 8'h5A);
        send_request(REQ_LOAD, 8'h11);
        send_request(REQ_PROC, 8'hA5);
        send_request(REQ_FINISH, 8'h00);
        // text only, then pattern only
        send_request(REQ_PROC, 8'h80);
        send_request(REQ_FINISH, 8'h00);
        send_request(REQ_LOAD, 8'h7F);
        send_request(REQ_FINISH, 8'h00);

        // random pairs, with idling switched off for the last stretch
        while (sent_count < NUM_ITEMS)
        begin
            idle_on = (sent_count < CALM_AFTER) && ($urandom_range(0, 3) != 0);
            send_string_pair();
        end
        idle_on   = 1'b0;
        req_valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #5000000;
        $display("FAIL");
        $finish;
    end

endmodule
